FILE: rtl/core/fpra_pkg.sv
// ----------------------------------------------------------------------------
// fpra_pkg: shared definitions for the partition allocator
// Partition table, widths of the job fields and the layout of a queued job.
// ----------------------------------------------------------------------------
package fpra_pkg;

	// partition table
	localparam int NUM_SLOTS = 7;
	localparam int SLOT_W    = 3;
	localparam int LAST_SLOT = NUM_SLOTS - 1;
	localparam logic [7:0] SLOT_SIZE [NUM_SLOTS] = '{
		8'd2, 8'd4, 8'd6, 8'd8, 8'd8, 8'd12, 8'd16
	};
	localparam logic [7:0] LARGEST_SIZE = 8'd16;

	// job queue
	localparam int QUEUE_DEPTH_DEF = 16;

	// field widths
	localparam int ID_W   = 10;
	localparam int SIZE_W = 8;
	localparam int DUR_W  = 16;
	localparam int TIME_W = 32;
	localparam int FAIL_W = 16;

	// operation codes on the mode field
	localparam logic MODE_ENQUEUE = 1'b0;
	localparam logic MODE_TICK    = 1'b1;

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [SIZE_W-1:0] size;
		logic [DUR_W-1:0]  dur;
		logic [TIME_W-1:0] start;
	} job_entry_t;

	// the largest partition takes any job, the others only one that fits
	function automatic logic slot_fits(input int slot, input logic [SIZE_W-1:0] size);
		return (slot == LAST_SLOT) || (size <= SLOT_SIZE[slot]);
	endfunction

	// round-robin successor of a slot index
	function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] slot);
		return (slot == SLOT_W'(LAST_SLOT)) ? '0 : slot + SLOT_W'(1);
	endfunction

endpackage

FILE: rtl/core/fixed_partition_round_robin_allocator.sv
// ----------------------------------------------------------------------------
// fixed_partition_round_robin_allocator
// Seven fixed partitions fed from a job queue, served one quantum a tick.
// ----------------------------------------------------------------------------
// Every input beat returns exactly one result beat. An enqueue beat pushes a
// job (or drops it when the queue is full) and then places waiting jobs into
// free partitions; a tick beat serves the next occupied partition round-robin
// and, when its job finishes, frees it and refills. One beat is worked on at
// a time and in_ready is low meanwhile. A placement is a queue read, then a
// slot search; the attempt that ends the fill stops at the queue read (queue
// empty) or after the slot search (head blocked). An enqueue is accepted,
// then makes at most one placement and the closing attempt, and then hands
// over the result; a dropped job goes straight to the handover, as does a
// tick on an empty table. Any other tick is accepted, scans the slots, goes
// through the shared subtractor for the remaining time and hands over. On
// completion the turnaround step and the fill loop (up to seven placements
// and the closing attempt) come before the handover. The handover waits
// while the previous result is still held in the output register. The queue
// is a single-port-write, registered-read memory; the fill loop reads the
// queue head before each slot search. No clearing pass is needed.
// ----------------------------------------------------------------------------
module fixed_partition_round_robin_allocator #(
	parameter int QUEUE_DEPTH = fpra_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        mode,
	input  logic [fpra_pkg::ID_W-1:0]   job_id,
	input  logic [fpra_pkg::SIZE_W-1:0] job_size,
	input  logic [fpra_pkg::DUR_W-1:0]  job_duration,
	input  logic [fpra_pkg::TIME_W-1:0] job_start_time,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        queue_full_drop,
	output logic                        job_completed,
	output logic [fpra_pkg::ID_W-1:0]   finished_job_id,
	output logic [fpra_pkg::TIME_W-1:0] turnaround,
	output logic [2:0]                  occupied_partitions,
	output logic [4:0]                  waiting_jobs,
	output logic [fpra_pkg::FAIL_W-1:0] failures,
	output logic [fpra_pkg::TIME_W-1:0] cycle_now,
	output logic                        table_idle
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int SUM_W = PTR_W + 1;
	localparam int SW    = fpra_pkg::SLOT_W;
	localparam int NS    = fpra_pkg::NUM_SLOTS;
	localparam int TW    = fpra_pkg::TIME_W;
	localparam int DW    = fpra_pkg::DUR_W;

	typedef enum logic [6:0] {
		ST_IDLE    = 7'b0000001,
		ST_FILL_RD = 7'b0000010,
		ST_FILL_PL = 7'b0000100,
		ST_SCAN    = 7'b0001000,
		ST_DEC     = 7'b0010000,
		ST_TAT     = 7'b0100000,
		ST_RESP    = 7'b1000000
	} state_t;

	state_t state_q;

	// partition table
	logic                         slot_valid_q [NS];
	logic [fpra_pkg::ID_W-1:0]    slot_job_q   [NS];
	logic [DW-1:0]                slot_rem_q   [NS];
	logic [TW-1:0]                slot_start_q [NS];
	logic [2:0]                   occ_q;

	// job queue
	fpra_pkg::job_entry_t         fifo_mem [QUEUE_DEPTH];
	fpra_pkg::job_entry_t         head_q;
	logic [PTR_W-1:0]             fifo_head_q;
	logic [CNT_W-1:0]             fifo_count_q;

	// service and statistics
	logic [SW-1:0]                serve_ptr_q;
	logic [SW-1:0]                scan_ptr_q;
	logic [TW-1:0]                cycle_q;
	logic [fpra_pkg::FAIL_W-1:0]  fail_q;

	// result under construction and the output register
	logic                         res_drop_q;
	logic                         res_done_q;
	logic [fpra_pkg::ID_W-1:0]    res_fid_q;
	logic [TW-1:0]                res_tat_q;
	logic                         res_idle_q;
	logic                         out_valid_q;
	logic                         out_drop_q;
	logic                         out_done_q;
	logic [fpra_pkg::ID_W-1:0]    out_fid_q;
	logic [TW-1:0]                out_tat_q;
	logic [2:0]                   out_occ_q;
	logic [4:0]                   out_wait_q;
	logic [fpra_pkg::FAIL_W-1:0]  out_fail_q;
	logic [TW-1:0]                out_cycle_q;
	logic                         out_idle_q;

	logic                         in_beat;
	logic                         fifo_full;
	logic [SUM_W-1:0]             tail_sum;
	logic [PTR_W-1:0]             tail_ptr;
	logic                         wr_en;
	fpra_pkg::job_entry_t         wr_data;
	logic                         rd_en;
	logic                         place_hit;
	logic [SW-1:0]                place_slot;
	logic [TW-1:0]                alu_a;
	logic [TW-1:0]                alu_b;
	logic [TW-1:0]                alu_y;
	logic [DW-1:0]                rem_new;
	logic                         out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_beat   = in_valid && in_ready;
	assign fifo_full = (fifo_count_q == CNT_W'(QUEUE_DEPTH));
	assign out_free  = !out_valid_q || out_ready;

	// tail position, wrapped back into the queue
	always_comb begin
		tail_sum = SUM_W'(fifo_head_q) + SUM_W'(fifo_count_q);
		if (tail_sum >= SUM_W'(QUEUE_DEPTH)) begin
			tail_sum = tail_sum - SUM_W'(QUEUE_DEPTH);
		end
		tail_ptr = tail_sum[PTR_W-1:0];
	end

	assign wr_en         = in_beat && (mode == fpra_pkg::MODE_ENQUEUE) && !fifo_full;
	assign wr_data.id    = job_id;
	assign wr_data.size  = job_size;
	assign wr_data.dur   = job_duration;
	assign wr_data.start = job_start_time;
	assign rd_en         = (state_q == ST_FILL_RD) && (fifo_count_q != '0);

	// queue memory: one write port, registered read of the head
	always_ff @(posedge clk) begin
		if (wr_en) begin
			fifo_mem[tail_ptr] <= wr_data;
		end
		if (rd_en) begin
			head_q <= fifo_mem[fifo_head_q];
		end
	end

	// first free partition that the head job fits, lowest index wins
	always_comb begin
		place_hit  = 1'b0;
		place_slot = '0;
		for (int s = NS - 1; s >= 0; s--) begin
			if (!slot_valid_q[s] && fpra_pkg::slot_fits(s, head_q.size)) begin
				place_hit  = 1'b1;
				place_slot = SW'(s);
			end
		end
	end

	// shared subtractor: remaining time less one, or turnaround
	always_comb begin
		if (state_q == ST_TAT) begin
			alu_a = cycle_q;
			alu_b = slot_start_q[scan_ptr_q];
		end else begin
			alu_a = TW'(slot_rem_q[scan_ptr_q]);
			alu_b = TW'(1);
		end
		alu_y   = alu_a - alu_b;
		rem_new = alu_y[DW-1:0];
	end

	// slot payload, no reset
	always_ff @(posedge clk) begin
		if (state_q == ST_FILL_PL && place_hit) begin
			slot_job_q[place_slot]   <= head_q.id;
			slot_rem_q[place_slot]   <= head_q.dur;
			slot_start_q[place_slot] <= head_q.start;
		end else if (state_q == ST_DEC) begin
			slot_rem_q[scan_ptr_q] <= rem_new;
		end
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			fifo_head_q  <= '0;
			fifo_count_q <= '0;
			serve_ptr_q  <= '0;
			scan_ptr_q   <= '0;
			cycle_q      <= '0;
			fail_q       <= '0;
			occ_q        <= '0;
			out_valid_q  <= 1'b0;
			for (int s = 0; s < NS; s++) begin
				slot_valid_q[s] <= 1'b0;
			end
		end else begin
			// load a new output beat, or drop the held one once taken
			if (state_q == ST_RESP && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_beat) begin
						if (mode == fpra_pkg::MODE_ENQUEUE) begin
							if (fifo_full) begin
								state_q <= ST_RESP;
							end else begin
								fifo_count_q <= fifo_count_q + CNT_W'(1);
								state_q      <= ST_FILL_RD;
							end
						end else if (occ_q == '0) begin
							state_q <= ST_RESP;
						end else begin
							scan_ptr_q <= serve_ptr_q;
							state_q    <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					// advance one slot a cycle until an occupied one turns up
					if (slot_valid_q[scan_ptr_q]) begin
						state_q <= ST_DEC;
					end else begin
						scan_ptr_q <= fpra_pkg::next_slot(scan_ptr_q);
					end
				end
				ST_DEC: begin
					serve_ptr_q <= fpra_pkg::next_slot(scan_ptr_q);
					if (rem_new == '0) begin
						state_q <= ST_TAT;
					end else begin
						cycle_q <= cycle_q + TW'(1);
						state_q <= ST_RESP;
					end
				end
				ST_TAT: begin
					slot_valid_q[scan_ptr_q] <= 1'b0;
					occ_q   <= occ_q - 3'd1;
					cycle_q <= cycle_q + TW'(1);
					state_q <= ST_FILL_RD;
				end
				ST_FILL_RD: begin
					state_q <= (fifo_count_q != '0) ? ST_FILL_PL : ST_RESP;
				end
				ST_FILL_PL: begin
					if (place_hit) begin
						slot_valid_q[place_slot] <= 1'b1;
						occ_q        <= occ_q + 3'd1;
						fifo_count_q <= fifo_count_q - CNT_W'(1);
						fifo_head_q  <= (fifo_head_q == PTR_W'(QUEUE_DEPTH - 1)) ?
							'0 : fifo_head_q + PTR_W'(1);
						if (place_slot == SW'(fpra_pkg::LAST_SLOT) &&
							head_q.size > fpra_pkg::LARGEST_SIZE && fail_q != '1) begin
							fail_q <= fail_q + fpra_pkg::FAIL_W'(1);
						end
						state_q <= ST_FILL_RD;
					end else begin
						state_q <= ST_RESP;
					end
				end
				ST_RESP: begin
					// hand the finished result to the output register
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result fields, built while the beat is worked on
	always_ff @(posedge clk) begin
		if (in_beat) begin
			res_drop_q <= (mode == fpra_pkg::MODE_ENQUEUE) && fifo_full;
			res_idle_q <= (mode == fpra_pkg::MODE_TICK) && (occ_q == '0);
			res_done_q <= 1'b0;
			res_fid_q  <= '0;
			res_tat_q  <= '0;
		end else if (state_q == ST_TAT) begin
			res_done_q <= 1'b1;
			res_fid_q  <= slot_job_q[scan_ptr_q];
			res_tat_q  <= alu_y;
		end
		if (state_q == ST_RESP && out_free) begin
			out_drop_q  <= res_drop_q;
			out_done_q  <= res_done_q;
			out_fid_q   <= res_fid_q;
			out_tat_q   <= res_tat_q;
			out_idle_q  <= res_idle_q;
			out_occ_q   <= occ_q;
			out_wait_q  <= 5'(fifo_count_q);
			out_fail_q  <= fail_q;
			out_cycle_q <= cycle_q;
		end
	end

	assign out_valid           = out_valid_q;
	assign queue_full_drop     = out_drop_q;
	assign job_completed       = out_done_q;
	assign finished_job_id     = out_fid_q;
	assign turnaround          = out_tat_q;
	assign occupied_partitions = out_occ_q;
	assign waiting_jobs        = out_wait_q;
	assign failures            = out_fail_q;
	assign cycle_now           = out_cycle_q;
	assign table_idle          = out_idle_q;

endmodule

FILE: rtl/core/fpra_chk.sv
// ----------------------------------------------------------------------------
// fpra_chk: port checker for the partition allocator
// Watches the result channel for consistent flags and a held stalled beat.
// ----------------------------------------------------------------------------
module fpra_chk (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic                        queue_full_drop,
	input logic                        job_completed,
	input logic [fpra_pkg::ID_W-1:0]   finished_job_id,
	input logic [fpra_pkg::TIME_W-1:0] turnaround,
	input logic [2:0]                  occupied_partitions,
	input logic                        table_idle
);

	// hold a stalled result beat
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(finished_job_id) &&
			$stable(turnaround) && $stable(job_completed))
		else $error("result beat changed while stalled");

	// a dropped enqueue reports no tick outcome
	a_drop_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && queue_full_drop |-> !job_completed && !table_idle)
		else $error("drop flagged together with a tick outcome");

	// an idle tick leaves every partition empty and finishes nothing
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && table_idle |-> !job_completed && occupied_partitions == 3'd0)
		else $error("idle tick with occupied partitions or a completion");

	// no job id or turnaround without a completion
	a_no_ghost: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !job_completed |-> finished_job_id == '0 && turnaround == '0)
		else $error("finished job fields set without a completion");

endmodule

bind fixed_partition_round_robin_allocator fpra_chk u_fpra_chk (.*);
